[src/salc_pkg.sv]
package salc_pkg;

  // cache geometry; the field widths of the access and result words follow from it
  localparam int ADDR_W         = 16;
  localparam int WAYS           = 4;
  localparam int BLOCK_ELEMENTS = 32;
  localparam int CACHE_ELEMENTS = 1024;

  localparam int SET_COUNT_RAW  = CACHE_ELEMENTS / (BLOCK_ELEMENTS * WAYS);
  localparam int NUM_SETS       = (SET_COUNT_RAW > 0) ? SET_COUNT_RAW : 1;

  localparam int OFF_W = $clog2(BLOCK_ELEMENTS);
  localparam int BLK_W = ADDR_W - OFF_W;
  localparam int SET_W = $clog2(NUM_SETS);
  localparam int TAG_W = BLK_W - SET_W;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W = WAY_W;
  localparam int CNT_W = 32;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = 1 + 1 + BLK_W + CNT_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // one set of the tag memory
  typedef struct packed {
    logic [WAYS-1:0][AGE_W-1:0] age;
    logic [WAYS-1:0][TAG_W-1:0] tag;
  } row_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic capture;  // take the address and start the set read
    logic update;   // compare, write the set back and load the result
  } cmd_t;

  typedef struct packed {
    logic slot_free;  // result register empty or being taken
  } status_t;

endpackage

[src/salc_ctrl.sv]
module salc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  salc_pkg::status_t status,
  output salc_pkg::cmd_t    cmd
);

  salc_pkg::state_t state_r;
  salc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= salc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    unique case (state_r)
      salc_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = salc_pkg::ST_LOOKUP;
        end
      end
      salc_pkg::ST_LOOKUP: begin
        // wait here while the previous result is still held
        if (status.slot_free) begin
          cmd.update = 1'b1;
          state_nxt  = salc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = salc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/salc_dpath.sv]
module salc_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [salc_pkg::ADDR_W-1:0]      in_addr,
  input  salc_pkg::cmd_t                   cmd,
  output salc_pkg::status_t                status,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [salc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int WAYS  = salc_pkg::WAYS;
  localparam int TAG_W = salc_pkg::TAG_W;
  localparam int SET_W = salc_pkg::SET_W;
  localparam int BLK_W = salc_pkg::BLK_W;
  localparam int WAY_W = salc_pkg::WAY_W;
  localparam int AGE_W = salc_pkg::AGE_W;
  localparam int CNT_W = salc_pkg::CNT_W;

  salc_pkg::row_t           mem [salc_pkg::NUM_SETS];
  salc_pkg::row_t           rd_row_r;
  logic [WAYS-1:0]          valid_r [salc_pkg::NUM_SETS];
  logic [TAG_W-1:0]         tag_r;
  logic [SET_W-1:0]         set_r;
  logic [CNT_W-1:0]         hit_cnt_r;
  logic [CNT_W-1:0]         hit_cnt_nxt;
  logic [CNT_W-1:0]         miss_cnt_r;
  logic [CNT_W-1:0]         miss_cnt_nxt;
  logic                     out_valid_r;
  logic                     out_hit_r;
  logic                     out_evict_r;
  logic [BLK_W-1:0]         out_evblk_r;

  logic [BLK_W-1:0]         in_blk;
  logic [SET_W-1:0]         in_set;
  logic [TAG_W-1:0]         in_tag;

  salc_pkg::row_t           row_nxt;
  logic [WAYS-1:0]          vld;
  logic [WAYS-1:0]          vld_nxt;
  logic                     found;
  logic                     have_free;
  logic                     have_old;
  logic [WAY_W-1:0]         hit_way;
  logic [WAY_W-1:0]         free_way;
  logic [WAY_W-1:0]         old_way;
  logic [WAY_W-1:0]         fill_way;
  logic [AGE_W-1:0]         hit_age;
  logic                     evict;
  logic [BLK_W-1:0]         evblk;

  assign in_blk = in_addr[salc_pkg::ADDR_W-1:salc_pkg::OFF_W];
  assign in_set = in_blk[SET_W-1:0];
  assign in_tag = in_blk[BLK_W-1:SET_W];

  assign status.slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_row_r <= mem[in_set];
      tag_r    <= in_tag;
      set_r    <= in_set;
    end
    if (cmd.update) begin
      mem[set_r] <= row_nxt;
    end
  end

  always_comb begin
    vld       = valid_r[set_r];
    found     = 1'b0;
    have_free = 1'b0;
    have_old  = 1'b0;
    hit_way   = '0;
    free_way  = '0;
    old_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (vld[w]) begin
        if (!found && rd_row_r.tag[w] == tag_r) begin
          found   = 1'b1;
          hit_way = WAY_W'(w);
        end
        if (!have_old || rd_row_r.age[w] > rd_row_r.age[old_way]) begin
          have_old = 1'b1;
          old_way  = WAY_W'(w);
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_way  = WAY_W'(w);
      end
    end

    hit_age  = rd_row_r.age[hit_way];
    evict    = !found && !have_free;
    fill_way = have_free ? free_way : old_way;
    row_nxt  = rd_row_r;
    vld_nxt  = vld;
    evblk    = '0;

    if (found) begin
      for (int w = 0; w < WAYS; w++) begin
        if (vld[w] && rd_row_r.age[w] < hit_age) begin
          row_nxt.age[w] = rd_row_r.age[w] + AGE_W'(1);
        end
      end
      row_nxt.age[hit_way] = '0;
    end else begin
      if (evict) begin
        evblk             = {rd_row_r.tag[old_way], set_r};
        vld_nxt[old_way]  = 1'b0;
      end
      for (int w = 0; w < WAYS; w++) begin
        if (vld_nxt[w]) begin
          row_nxt.age[w] = rd_row_r.age[w] + AGE_W'(1);
        end
      end
      row_nxt.tag[fill_way] = tag_r;
      row_nxt.age[fill_way] = '0;
      vld_nxt[fill_way]     = 1'b1;
    end

    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    // counts hold at all ones
    if (found) begin
      if (hit_cnt_r != '1) begin
        hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
      end
    end else begin
      if (miss_cnt_r != '1) begin
        miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < salc_pkg::NUM_SETS; s++) begin
        valid_r[s] <= '0;
      end
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        valid_r[set_r] <= vld_nxt;
        hit_cnt_r      <= hit_cnt_nxt;
        miss_cnt_r     <= miss_cnt_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r   <= found;
      out_evict_r <= evict;
      out_evblk_r <= evblk;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(salc_pkg::OUT_TDATA_W - salc_pkg::OUT_FIELD_W)'(0),
                       miss_cnt_r, hit_cnt_r, out_evblk_r, out_evict_r, out_hit_r};

endmodule

[src/set_assoc_lru_cache_tags.sv]
// tag and replacement logic of a 4-way set-associative cache with true lru
// (8 sets of 32-element blocks, 1024 elements); no data is stored
// input channel: in_tdata carries the 16-bit element address of one access
// result channel: one word per access with hit, eviction, evicted block
// address (zero when nothing is evicted) and saturating hit and miss counts
// that include this access
// an accepted access reads its set from the tag memory into a register;
// in the lookup state it then compares all ways and writes the updated tags
// and ages back while loading the result register, once that register is free
// a new access is taken only after the current one has written its set back,
// since each access reads and then writes back its tag memory row
// in_tready is high while no access is in flight; a result waits in the
// output register while the receiver stalls, and the next access is taken
// meanwhile but holds in its compare cycle until that register frees
// reset (rst_n low, synchronous) clears all valid bits, both counters and
// the result valid flag; tag contents need no clearing
module set_assoc_lru_cache_tags (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] address
  input  logic [salc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] hit, [1] eviction, [12:2] evicted_block, [44:13] hit_total,
  // [76:45] miss_total, [79:77] zero
  output logic [salc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  salc_pkg::cmd_t    cmd;
  salc_pkg::status_t status;

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  salc_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_addr    (in_tdata[salc_pkg::ADDR_W-1:0]),
    .cmd        (cmd),
    .status     (status),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

[src/salc_checker.sv]
module salc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [salc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [salc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // one access at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an access is in flight");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("hit and eviction both set");

  // evicted block reads zero when nothing was evicted
  a_evblk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[12:2] == 11'd0)
    else $error("evicted block nonzero without eviction");

endmodule

bind set_assoc_lru_cache_tags salc_checker u_salc_checker (.*);

[bench/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import salc_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 150;
  localparam int PHASE_ITEMS = 500;
  localparam int MAX_PRINTS  = 30;

  typedef struct packed {
    logic             hit;
    logic             eviction;
    logic [BLK_W-1:0] evicted_block;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
  } access_result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              typed;
    access_result_t    want;
  } probe_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // hold-off request for the receiver, raised once by the stimulus
  logic hold_req = 1'b0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  // lookup model state
  int               tag_store [NUM_SETS][WAYS];
  bit               way_valid [NUM_SETS][WAYS];
  int               way_age   [NUM_SETS][WAYS];
  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] miss_count;

  access_result_t pending_results[$];
  logic [BLK_W-1:0] hot_blocks [12];

  int errors = 0;
  int words_seen = 0;
  int hits_seen = 0;
  int evictions_seen = 0;

  // first rows touch sets 0 and 7, fill set 0, hit in it and then push out its oldest line
  probe_t directed_probes [0:16] = '{
    '{16'h0000, 1'b1, '{1'b0, 1'b0, 11'd0, 32'd0, 32'd1}},
    '{16'h001F, 1'b1, '{1'b1, 1'b0, 11'd0, 32'd1, 32'd1}},
    '{16'hFFFF, 1'b1, '{1'b0, 1'b0, 11'd0, 32'd1, 32'd2}},
    '{16'hFFE0, 1'b1, '{1'b1, 1'b0, 11'd0, 32'd2, 32'd2}},
    '{16'h0100, 1'b1, '{1'b0, 1'b0, 11'd0, 32'd2, 32'd3}},
    '{16'h0200, 1'b1, '{1'b0, 1'b0, 11'd0, 32'd2, 32'd4}},
    '{16'h0300, 1'b1, '{1'b0, 1'b0, 11'd0, 32'd2, 32'd5}},
    '{16'h0010, 1'b1, '{1'b1, 1'b0, 11'd0, 32'd3, 32'd5}},
    '{16'h0400, 1'b1, '{1'b0, 1'b1, 11'd8, 32'd3, 32'd6}},
    '{16'h0100, 1'b0, '0},
    '{16'hF800, 1'b0, '0},
    '{16'h0300, 1'b0, '0},
    '{16'h5555, 1'b0, '0},
    '{16'hAAAA, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h8000, 1'b0, '0},
    '{16'h0001, 1'b0, '0}
  };

  set_assoc_lru_cache_tags dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic access_result_t lookup_and_update(input logic [ADDR_W-1:0] a);
    int blk;
    int set_idx;
    int tag_val;
    int found;
    int free_way;
    int oldest;
    int hit_age;
    int victim;
    access_result_t r;
    blk = int'(a) >> OFF_W;
    set_idx = blk % NUM_SETS;
    tag_val = blk / NUM_SETS;
    found = -1;
    free_way = -1;
    oldest = -1;
    r = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (way_valid[set_idx][w]) begin
        if (found < 0 && tag_store[set_idx][w] == tag_val) found = w;
        if (oldest < 0 || way_age[set_idx][w] > way_age[set_idx][oldest]) oldest = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (found >= 0) begin
      hit_age = way_age[set_idx][found];
      for (int w = 0; w < WAYS; w++)
        if (way_valid[set_idx][w] && way_age[set_idx][w] < hit_age) way_age[set_idx][w]++;
      way_age[set_idx][found] = 0;
      r.hit = 1'b1;
      if (hit_count != '1) hit_count++;
    end else begin
      if (free_way >= 0) begin
        victim = free_way;
      end else begin
        victim = oldest;
        r.eviction = 1'b1;
        r.evicted_block = BLK_W'(tag_store[set_idx][victim] * NUM_SETS + set_idx);
        way_valid[set_idx][victim] = 1'b0;
      end
      for (int w = 0; w < WAYS; w++)
        if (way_valid[set_idx][w]) way_age[set_idx][w]++;
      tag_store[set_idx][victim] = tag_val;
      way_valid[set_idx][victim] = 1'b1;
      way_age[set_idx][victim] = 0;
      if (miss_count != '1) miss_count++;
    end
    r.hit_total = hit_count;
    r.miss_total = miss_count;
    return r;
  endfunction

  // mostly a small working set and single-set thrashing, some fully random noise
  function automatic logic [ADDR_W-1:0] next_address();
    int pick;
    int slot;
    int set_idx;
    logic [BLK_W-1:0] blk;
    pick = $urandom_range(99);
    slot = $urandom_range(11);
    if (pick < 55) begin
      blk = hot_blocks[slot];
    end else if (pick < 75) begin
      set_idx = $urandom_range(NUM_SETS - 1);
      blk = BLK_W'($urandom_range(5) * NUM_SETS + set_idx);
    end else if (pick < 85) begin
      blk = BLK_W'($urandom);
      hot_blocks[slot] = blk;
    end else begin
      return ADDR_W'($urandom);
    end
    return {blk, OFF_W'($urandom)};
  endfunction

  task automatic send_access(input logic [ADDR_W-1:0] a, input logic typed,
                             input access_result_t want);
    access_result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= a;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = lookup_and_update(a);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // result monitor
  initial begin
    access_result_t got;
    access_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.hit = out_tdata[0];
        got.eviction = out_tdata[1];
        got.evicted_block = out_tdata[2 +: BLK_W];
        got.hit_total = out_tdata[2 + BLK_W +: CNT_W];
        got.miss_total = out_tdata[2 + BLK_W + CNT_W +: CNT_W];
        words_seen++;
        hits_seen += int'(got.hit);
        evictions_seen += int'(got.eviction);
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", 64'(got), 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (got.hit != want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
          if (got.eviction != want.eviction)
            report_mismatch("eviction", 64'(got.eviction), 64'(want.eviction));
          if (got.evicted_block != want.evicted_block)
            report_mismatch("evicted_block", 64'(got.evicted_block),
                            64'(want.evicted_block));
          if (got.hit_total != want.hit_total)
            report_mismatch("hit_total", 64'(got.hit_total), 64'(want.hit_total));
          if (got.miss_total != want.miss_total)
            report_mismatch("miss_total", 64'(got.miss_total), 64'(want.miss_total));
          if (out_tdata[OUT_TDATA_W-1:OUT_FIELD_W] != '0)
            report_mismatch("pad bits", 64'(out_tdata[OUT_TDATA_W-1:OUT_FIELD_W]), 64'd0);
        end
      end
    end
  end

  // receiver side, with one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    for (int s = 0; s < NUM_SETS; s++)
      for (int w = 0; w < WAYS; w++) begin
        tag_store[s][w] = 0;
        way_valid[s][w] = 1'b0;
        way_age[s][w] = 0;
      end
    hit_count = '0;
    miss_count = '0;
    for (int i = 0; i < 12; i++) hot_blocks[i] = BLK_W'($urandom);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    src_idle_pct <= 17;
    sink_idle_pct <= 66;
    @(posedge clk);

    foreach (directed_probes[i])
      send_access(directed_probes[i].addr, directed_probes[i].typed, directed_probes[i].want);

    for (int i = 0; i < PHASE_ITEMS; i++) send_access(next_address(), 1'b0, '0);

    src_idle_pct <= 66;
    sink_idle_pct <= 17;
    for (int i = 0; i < PHASE_ITEMS; i++) send_access(next_address(), 1'b0, '0);

    // pause the sender until the block has drained
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);

    src_idle_pct <= 0;
    sink_idle_pct <= 0;
    hold_req <= 1'b1;
    for (int i = 0; i < PHASE_ITEMS; i++) send_access(next_address(), 1'b0, '0);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d accesses: %0d hits, %0d misses, %0d evictions", words_seen,
             hits_seen, words_seen - hits_seen, evictions_seen);
    $display("idle mixes on both sides, one long output stall and one full drain");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
